>>> design/line_ellipse_intersection_defines.svh
// Assertion macros shared by the design files.
// Each macro expands to a labeled concurrent assertion in simulation and to nothing
// in synthesis.
`ifndef LINE_ELLIPSE_INTERSECTION_DEFINES_SVH
`define LINE_ELLIPSE_INTERSECTION_DEFINES_SVH
`ifndef SYNTHESIS
// The condition must hold at every clock edge outside reset.
`define LEI_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: invariant");
// When the trigger holds, the consequence must hold in the same cycle.
`define LEI_ASSERT_IMPLY(label, clk, rst, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error("assertion failed: implication");
// When the trigger holds, the consequence must hold in the next cycle.
`define LEI_ASSERT_NEXT(label, clk, rst, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("assertion failed: next cycle");
`else
`define LEI_ASSERT_ALWAYS(label, clk, rst, cond)
`define LEI_ASSERT_IMPLY(label, clk, rst, trig, cons)
`define LEI_ASSERT_NEXT(label, clk, rst, trig, cons)
`endif
`endif

>>> design/lei_pkg.sv
`timescale 1ns / 1ps
package lei_pkg;

  // Status that travels with each request from the front part to the back part.
  typedef struct packed {
    logic hit;
    logic m_neg;
    logic ux_neg;
    logic uy_neg;
  } lei_flags_t;

  // Depth of the queue between the front and back parts.
  localparam int QDEPTH = 2;

  function automatic int lei_max(input int x, input int y);
    return (x > y) ? x : y;
  endfunction

endpackage

>>> design/lei_mul.sv
`timescale 1ns / 1ps
// Pipelined shift-add multiplier: one partial product per stage.
module lei_mul #(
  parameter int AW = 8,
  parameter int BW = 8,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid_in,
  input  logic [AW-1:0]        a,
  input  logic [BW-1:0]        b,
  input  logic [SW-1:0]        side_in,
  output logic                 valid_out,
  output logic [AW+BW-1:0]     p,
  output logic [SW-1:0]        side_out
);
  localparam int PW = AW + BW;

  logic          vld [0:BW];
  logic [PW-1:0] acc [0:BW];
  logic [AW-1:0] av  [0:BW];
  logic [BW-1:0] bv  [0:BW];
  logic [SW-1:0] sv  [0:BW];

  assign vld[0] = valid_in;
  assign acc[0] = '0;
  assign av[0]  = a;
  assign bv[0]  = b;
  assign sv[0]  = side_in;

  for (genvar i = 0; i < BW; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      acc[i+1] <= bv[i][i] ? (acc[i] + (PW'(av[i]) << i)) : acc[i];
      av[i+1]  <= av[i];
      bv[i+1]  <= bv[i];
      sv[i+1]  <= sv[i];
    end
  end

  assign valid_out = vld[BW];
  assign p         = acc[BW];
  assign side_out  = sv[BW];
endmodule

>>> design/lei_isqrt.sv
`timescale 1ns / 1ps
// Pipelined floor square root, one result bit per stage.
module lei_isqrt #(
  parameter int TW = 16,
  parameter int SW = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid_in,
  input  logic [TW-1:0]     t,
  input  logic [SW-1:0]     side_in,
  output logic              valid_out,
  output logic [TW/2-1:0]   r,
  output logic              exact,
  output logic [SW-1:0]     side_out
);
  localparam int RW = TW / 2;

  logic          vld  [0:RW];
  logic [RW:0]   rem  [0:RW];
  logic [RW-1:0] root [0:RW];
  logic [TW-1:0] tv   [0:RW];
  logic [SW-1:0] sv   [0:RW];

  assign vld[0]  = valid_in;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign tv[0]   = t;
  assign sv[0]   = side_in;

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic [RW+2:0] cur;
    logic [RW+2:0] trial;
    logic          ge;

    assign cur   = {rem[i], tv[i][TW-1:TW-2]};
    assign trial = (RW+3)'({root[i], 2'b01});
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      rem[i+1]  <= ge ? (RW+1)'(cur - trial) : (RW+1)'(cur);
      root[i+1] <= {root[i][RW-2:0], ge};
      tv[i+1]   <= tv[i] << 2;
      sv[i+1]   <= sv[i];
    end
  end

  assign valid_out = vld[RW];
  assign r         = root[RW];
  assign exact     = (rem[RW] == '0);
  assign side_out  = sv[RW];
endmodule

>>> design/lei_div.sv
`timescale 1ns / 1ps
// Pipelined floor division of a signed numerator by a positive denominator, saturated to
// a signed QW-bit word. A range check, then one quotient bit per stage, then the rounding
// fix-up.
module lei_div #(
  parameter int NW = 16,
  parameter int DW = 16,
  parameter int QW = 8,
  parameter int SW = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           valid_in,
  input  logic           neg,
  input  logic [NW-1:0]  mag,
  input  logic [DW-1:0]  den,
  input  logic [SW-1:0]  side_in,
  output logic           valid_out,
  output logic [QW-1:0]  q,
  output logic [SW-1:0]  side_out
);
  localparam int CW = lei_pkg::lei_max(NW, DW + QW);

  logic          vld  [0:QW];
  logic          sneg [0:QW];
  logic          spos [0:QW];
  logic          sng  [0:QW];
  logic [CW-1:0] rem  [0:QW];
  logic [DW-1:0] dv   [0:QW];
  logic [QW-1:0] qv   [0:QW];
  logic [SW-1:0] sv   [0:QW];

  logic [CW-1:0] limit;
  logic [QW-1:0] q_adj;
  logic [QW-1:0] q_fin;

  // The quotient leaves the word when |num| reaches den * 2^(QW-1); a negative
  // quotient may still reach exactly -2^(QW-1).
  assign limit = CW'(den) << (QW - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    spos[0] <= !neg && (CW'(mag) >= limit);
    sneg[0] <= neg && (CW'(mag) > limit);
    sng[0]  <= neg;
    rem[0]  <= CW'(mag);
    dv[0]   <= den;
    qv[0]   <= '0;
    sv[0]   <= side_in;
  end

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [CW-1:0] cmp;
    logic          ge;

    assign cmp = CW'(dv[j]) << (QW - 1 - j);
    assign ge  = (rem[j] >= cmp);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      rem[j+1]  <= ge ? (rem[j] - cmp) : rem[j];
      qv[j+1]   <= {qv[j][QW-2:0], ge};
      spos[j+1] <= spos[j];
      sneg[j+1] <= sneg[j];
      sng[j+1]  <= sng[j];
      dv[j+1]   <= dv[j];
      sv[j+1]   <= sv[j];
    end
  end

  // A negative numerator rounds toward minus infinity: -(q + 1) when inexact.
  assign q_adj = qv[QW] + QW'(rem[QW] != '0);

  always_comb begin
    priority if (spos[QW]) begin
      q_fin = {1'b0, {(QW-1){1'b1}}};
    end else if (sneg[QW]) begin
      q_fin = {1'b1, {(QW-1){1'b0}}};
    end else if (sng[QW]) begin
      q_fin = (~q_adj) + 1'b1;
    end else begin
      q_fin = qv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    q        <= q_fin;
    side_out <= sv[QW];
  end
endmodule

>>> design/lei_front.sv
`timescale 1ns / 1ps
// Front part: forms the exact products, classifies the request (hit or not) and
// prepares the radicands and root offsets for the back part.
module lei_front #(
  parameter int W   = 32,
  parameter int F   = 16,
  parameter int DW  = 129,
  parameter int TSW = 322,
  parameter int UXW = 144,
  parameter int UYW = 160
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid_in,
  input  logic [W-2:0]        x_radius,
  input  logic [W-2:0]        y_radius,
  input  logic signed [W-1:0] slope,
  input  logic signed [W-1:0] intercept,
  output logic                valid_out,
  output lei_pkg::lei_flags_t flags_out,
  output logic [DW-1:0]       den,
  output logic [TSW-1:0]      tx,
  output logic [TSW-1:0]      ty,
  output logic [UXW-1:0]      ux,
  output logic [UYW-1:0]      uy
);
  localparam int TXCW = 4 * W + DW;

  typedef struct packed {
    logic a_zero;
    logic b_zero;
    logic m_neg;
    logic k_neg;
  } lei_sign_t;

  lei_sign_t    s0_sgn;
  logic [W-1:0] a_w;
  logic [W-1:0] b_w;
  logic [W-1:0] m_mag;
  logic [W-1:0] k_mag;

  assign a_w    = W'(x_radius);
  assign b_w    = W'(y_radius);
  assign m_mag  = slope[W-1] ? ((~slope) + 1'b1) : slope;
  assign k_mag  = intercept[W-1] ? ((~intercept) + 1'b1) : intercept;
  assign s0_sgn = '{a_zero: (x_radius == '0), b_zero: (y_radius == '0),
                    m_neg: slope[W-1], k_neg: intercept[W-1]};

  // First level of squares and cross products.
  logic           v1;
  lei_sign_t      s1_sgn;
  logic [W-1:0]   s1_kmag;
  logic [2*W-1:0] a2, b2, m2, k2, ab, mk;

  lei_mul #(.AW(W), .BW(W), .SW(W + 4)) u_aa (
    .clk(clk), .rst(rst), .valid_in(valid_in), .a(a_w), .b(a_w),
    .side_in({s0_sgn, k_mag}), .valid_out(v1), .p(a2), .side_out({s1_sgn, s1_kmag}));
  lei_mul #(.AW(W), .BW(W), .SW(1)) u_bb (
    .clk(clk), .rst(rst), .valid_in(valid_in), .a(b_w), .b(b_w),
    .side_in(1'b0), .valid_out(), .p(b2), .side_out());
  lei_mul #(.AW(W), .BW(W), .SW(1)) u_mm (
    .clk(clk), .rst(rst), .valid_in(valid_in), .a(m_mag), .b(m_mag),
    .side_in(1'b0), .valid_out(), .p(m2), .side_out());
  lei_mul #(.AW(W), .BW(W), .SW(1)) u_kk (
    .clk(clk), .rst(rst), .valid_in(valid_in), .a(k_mag), .b(k_mag),
    .side_in(1'b0), .valid_out(), .p(k2), .side_out());
  lei_mul #(.AW(W), .BW(W), .SW(1)) u_ab (
    .clk(clk), .rst(rst), .valid_in(valid_in), .a(a_w), .b(b_w),
    .side_in(1'b0), .valid_out(), .p(ab), .side_out());
  lei_mul #(.AW(W), .BW(W), .SW(1)) u_mk (
    .clk(clk), .rst(rst), .valid_in(valid_in), .a(m_mag), .b(k_mag),
    .side_in(1'b0), .valid_out(), .p(mk), .side_out());

  // Second level.
  logic           v2;
  lei_sign_t      s2_sgn;
  logic [2*W-1:0] s2_b2, s2_k2, s2_m2;
  logic [4*W-1:0] a2m2, ab2, amk, bk;

  lei_mul #(.AW(2*W), .BW(2*W), .SW(6*W + 4)) u_a2m2 (
    .clk(clk), .rst(rst), .valid_in(v1), .a(a2), .b(m2),
    .side_in({s1_sgn, b2, k2, m2}), .valid_out(v2), .p(a2m2),
    .side_out({s2_sgn, s2_b2, s2_k2, s2_m2}));
  lei_mul #(.AW(2*W), .BW(2*W), .SW(1)) u_ab2 (
    .clk(clk), .rst(rst), .valid_in(v1), .a(ab), .b(ab),
    .side_in(1'b0), .valid_out(), .p(ab2), .side_out());
  lei_mul #(.AW(2*W), .BW(2*W), .SW(1)) u_amk (
    .clk(clk), .rst(rst), .valid_in(v1), .a(a2), .b(mk),
    .side_in(1'b0), .valid_out(), .p(amk), .side_out());
  lei_mul #(.AW(2*W), .BW(2*W), .SW(1)) u_bk (
    .clk(clk), .rst(rst), .valid_in(v1), .a(b2), .b((2*W)'(s1_kmag)),
    .side_in(1'b0), .valid_out(), .p(bk), .side_out());

  // Classification: den = b^2 2^2F + a^2 m^2, S = den - k^2 2^2F.
  logic [DW-1:0]       den_c;
  logic [DW:0]         s_c;
  logic                hit_c;
  logic [DW-1:0]       spos_c;
  lei_pkg::lei_flags_t flags_c;

  assign den_c  = DW'(a2m2) + (DW'(s2_b2) << (2 * F));
  assign s_c    = (DW+1)'(den_c) - ((DW+1)'(s2_k2) << (2 * F));
  assign hit_c  = !s2_sgn.a_zero && (den_c != '0) && (s2_sgn.b_zero || !s_c[DW]);
  assign spos_c = (s2_sgn.b_zero || !hit_c) ? '0 : s_c[DW-1:0];
  assign flags_c = '{hit: hit_c, m_neg: s2_sgn.m_neg,
                     ux_neg: (s2_sgn.m_neg == s2_sgn.k_neg), uy_neg: s2_sgn.k_neg};

  logic                c_valid;
  lei_pkg::lei_flags_t c_flags;
  logic [DW-1:0]       c_den;
  logic [DW-1:0]       c_spos;
  logic [4*W-1:0]      c_ab2;
  logic [2*W-1:0]      c_m2;
  logic [UXW-1:0]      c_ux;
  logic [UYW-1:0]      c_uy;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    c_flags <= flags_c;
    c_den   <= den_c;
    c_spos  <= spos_c;
    c_ab2   <= ab2;
    c_m2    <= s2_m2;
    c_ux    <= UXW'(amk) << F;
    c_uy    <= UYW'(bk) << (2 * F);
  end

  // Third level: a^2 b^2 S.
  logic                v3;
  logic [TXCW-1:0]     txc;
  lei_pkg::lei_flags_t s3_flags;
  logic [DW-1:0]       s3_den;
  logic [2*W-1:0]      s3_m2;
  logic [UXW-1:0]      s3_ux;
  logic [UYW-1:0]      s3_uy;

  lei_mul #(.AW(4*W), .BW(DW), .SW(4 + DW + 2*W + UXW + UYW)) u_txc (
    .clk(clk), .rst(rst), .valid_in(c_valid), .a(c_ab2), .b(c_spos),
    .side_in({c_flags, c_den, c_m2, c_ux, c_uy}), .valid_out(v3), .p(txc),
    .side_out({s3_flags, s3_den, s3_m2, s3_ux, s3_uy}));

  // Fourth level: the y radicand carries a further m^2.
  logic [TXCW+2*W-1:0] ty_p;
  logic [TXCW-1:0]     txc4;

  lei_mul #(.AW(TXCW), .BW(2*W), .SW(4 + DW + TXCW + UXW + UYW)) u_ty (
    .clk(clk), .rst(rst), .valid_in(v3), .a(txc), .b(s3_m2),
    .side_in({s3_flags, s3_den, txc, s3_ux, s3_uy}), .valid_out(valid_out), .p(ty_p),
    .side_out({flags_out, den, txc4, ux, uy}));

  assign tx = TSW'(txc4) << (2 * F);
  assign ty = TSW'(ty_p);
endmodule

>>> design/lei_back.sv
`timescale 1ns / 1ps
// Back part: square roots of both radicands, the four root numerators, four
// dividers and the result register.
module lei_back #(
  parameter int W   = 32,
  parameter int DW  = 129,
  parameter int TSW = 322,
  parameter int UXW = 144,
  parameter int UYW = 160
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid_in,
  input  lei_pkg::lei_flags_t flags_in,
  input  logic [DW-1:0]       den,
  input  logic [TSW-1:0]      tx,
  input  logic [TSW-1:0]      ty,
  input  logic [UXW-1:0]      ux,
  input  logic [UYW-1:0]      uy,
  output logic                done,
  output logic                hit,
  output logic [W-1:0]        x_first,
  output logic [W-1:0]        y_first,
  output logic [W-1:0]        x_second,
  output logic [W-1:0]        y_second
);
  localparam int RW  = TSW / 2;
  localparam int NSW = lei_pkg::lei_max(lei_pkg::lei_max(UXW, UYW), RW + 1) + 2;

  logic                vs;
  lei_pkg::lei_flags_t fs;
  logic [DW-1:0]       dens;
  logic [UXW-1:0]      uxs;
  logic [UYW-1:0]      uys;
  logic [RW-1:0]       rx, ry;
  logic                ex, ey;

  lei_isqrt #(.TW(TSW), .SW(4 + DW + UXW + UYW)) u_sqx (
    .clk(clk), .rst(rst), .valid_in(valid_in), .t(tx),
    .side_in({flags_in, den, ux, uy}), .valid_out(vs), .r(rx), .exact(ex),
    .side_out({fs, dens, uxs, uys}));
  lei_isqrt #(.TW(TSW), .SW(1)) u_sqy (
    .clk(clk), .rst(rst), .valid_in(valid_in), .t(ty), .side_in(1'b0),
    .valid_out(), .r(ry), .exact(ey), .side_out());

  // The smaller root subtracts the rounded-up square root.
  logic [NSW-1:0] uxe, uye, ux_s, uy_s;
  logic [NSW-1:0] xlo, xhi, ylo, yhi, yf, ysec;

  assign uxe  = NSW'(uxs);
  assign uye  = NSW'(uys);
  assign ux_s = fs.ux_neg ? ('0 - uxe) : uxe;
  assign uy_s = fs.uy_neg ? ('0 - uye) : uye;
  assign xlo  = ux_s - (NSW'(rx) + NSW'(!ex));
  assign xhi  = ux_s + NSW'(rx);
  assign ylo  = uy_s - (NSW'(ry) + NSW'(!ey));
  assign yhi  = uy_s + NSW'(ry);
  assign yf   = fs.m_neg ? yhi : ylo;
  assign ysec = fs.m_neg ? ylo : yhi;

  logic           n_valid, n_hit;
  logic [DW-1:0]  n_den;
  logic           n_xf, n_yf, n_xs, n_ys;
  logic [NSW-1:0] m_xf, m_yf, m_xs, m_ys;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_valid <= 1'b0;
    end else begin
      n_valid <= vs;
    end
  end

  always_ff @(posedge clk) begin
    n_hit <= fs.hit;
    n_den <= dens;
    n_xf  <= xlo[NSW-1];
    n_xs  <= xhi[NSW-1];
    n_yf  <= yf[NSW-1];
    n_ys  <= ysec[NSW-1];
    m_xf  <= xlo[NSW-1] ? ('0 - xlo) : xlo;
    m_xs  <= xhi[NSW-1] ? ('0 - xhi) : xhi;
    m_yf  <= yf[NSW-1] ? ('0 - yf) : yf;
    m_ys  <= ysec[NSW-1] ? ('0 - ysec) : ysec;
  end

  logic         d_valid, d_hit;
  logic [W-1:0] q_xf, q_yf, q_xs, q_ys;

  lei_div #(.NW(NSW), .DW(DW), .QW(W), .SW(1)) u_dxf (
    .clk(clk), .rst(rst), .valid_in(n_valid), .neg(n_xf), .mag(m_xf), .den(n_den),
    .side_in(n_hit), .valid_out(d_valid), .q(q_xf), .side_out(d_hit));
  lei_div #(.NW(NSW), .DW(DW), .QW(W), .SW(1)) u_dyf (
    .clk(clk), .rst(rst), .valid_in(n_valid), .neg(n_yf), .mag(m_yf), .den(n_den),
    .side_in(1'b0), .valid_out(), .q(q_yf), .side_out());
  lei_div #(.NW(NSW), .DW(DW), .QW(W), .SW(1)) u_dxs (
    .clk(clk), .rst(rst), .valid_in(n_valid), .neg(n_xs), .mag(m_xs), .den(n_den),
    .side_in(1'b0), .valid_out(), .q(q_xs), .side_out());
  lei_div #(.NW(NSW), .DW(DW), .QW(W), .SW(1)) u_dys (
    .clk(clk), .rst(rst), .valid_in(n_valid), .neg(n_ys), .mag(m_ys), .den(n_den),
    .side_in(1'b0), .valid_out(), .q(q_ys), .side_out());

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    hit      <= d_hit;
    x_first  <= d_hit ? q_xf : '0;
    y_first  <= d_hit ? q_yf : '0;
    x_second <= d_hit ? q_xs : '0;
    y_second <= d_hit ? q_ys : '0;
  end
endmodule

>>> design/line_ellipse_intersection.sv
`timescale 1ns / 1ps
// Line / ellipse intersection in signed fixed point (WORD_BITS wide, FRAC_BITS fraction).
// Requests come in on start with x_radius, y_radius, slope and intercept; a request
// is taken at each clock edge where start is high and busy is low. The block takes one
// request every cycle: every stage is a register, so busy stays low in normal use.
// Each result appears on hit, x_first, y_first, x_second and y_second for exactly one cycle,
// marked by done, in request order. The receiver cannot hold results off and none is needed.
// The front part holds the shift-add multiplier chains and the hit test, with
// DW = max(4W, 2W + 2F) + 1; the queue and its registered read lie between the parts;
// the back part holds the square roots (TSW is the radicand width, about 6W + DW rounded
// up to even), the numerator register, the dividers and the result register. The depth
// is set mostly by the bit-per-stage square root and multiplier chains.
// A miss returns hit = 0 and all coordinates 0. Synchronous reset empties every stage
// and the queue; requests in flight are dropped and no done follows them.
`include "line_ellipse_intersection_defines.svh"
module line_ellipse_intersection #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [WORD_BITS-2:0]        x_radius,
  input  logic [WORD_BITS-2:0]        y_radius,
  input  logic signed [WORD_BITS-1:0] slope,
  input  logic signed [WORD_BITS-1:0] intercept,
  output logic                        done,
  output logic                        hit,
  output logic signed [WORD_BITS-1:0] x_first,
  output logic signed [WORD_BITS-1:0] y_first,
  output logic signed [WORD_BITS-1:0] x_second,
  output logic signed [WORD_BITS-1:0] y_second
);
  localparam int W    = WORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int DW   = lei_pkg::lei_max(4 * W, 2 * W + 2 * F) + 1;
  localparam int TXCW = 4 * W + DW;
  localparam int TMAX = lei_pkg::lei_max(TXCW + 2 * F, TXCW + 2 * W);
  localparam int TSW  = TMAX + (TMAX % 2);
  localparam int UXW  = 4 * W + F;
  localparam int UYW  = 4 * W + 2 * F;
  localparam int EW   = 4 + DW + 2 * TSW + UXW + UYW;
  localparam int QAW  = $clog2(lei_pkg::QDEPTH);

  // Front part.
  logic                accept;
  logic                f_valid;
  lei_pkg::lei_flags_t f_flags;
  logic [DW-1:0]       f_den;
  logic [TSW-1:0]      f_tx, f_ty;
  logic [UXW-1:0]      f_ux;
  logic [UYW-1:0]      f_uy;

  assign accept = start && !busy;

  lei_front #(.W(W), .F(F), .DW(DW), .TSW(TSW), .UXW(UXW), .UYW(UYW)) u_front (
    .clk(clk), .rst(rst), .valid_in(accept),
    .x_radius(x_radius), .y_radius(y_radius),
    .slope(slope), .intercept(intercept),
    .valid_out(f_valid), .flags_out(f_flags), .den(f_den),
    .tx(f_tx), .ty(f_ty), .ux(f_ux), .uy(f_uy));

  // Short queue between the parts. The back part drains one entry per cycle.
  logic [EW-1:0]  q_mem [0:lei_pkg::QDEPTH-1];
  logic [QAW-1:0] q_wr_ptr, q_rd_ptr;
  logic [QAW:0]   q_count;
  logic           q_push, q_pop;

  assign q_push = f_valid;
  assign q_pop  = (q_count != '0);
  assign busy   = (q_count == (QAW+1)'(lei_pkg::QDEPTH));

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem[q_wr_ptr] <= {f_flags, f_den, f_tx, f_ty, f_ux, f_uy};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr_ptr <= '0;
      q_rd_ptr <= '0;
      q_count  <= '0;
    end else begin
      if (q_push) begin
        q_wr_ptr <= q_wr_ptr + 1'b1;
      end
      if (q_pop) begin
        q_rd_ptr <= q_rd_ptr + 1'b1;
      end
      unique case ({q_push, q_pop})
        2'b10:   q_count <= q_count + 1'b1;
        2'b01:   q_count <= q_count - 1'b1;
        default: q_count <= q_count;
      endcase
    end
  end

  // Registered read of the queue head into the back part.
  logic                b_valid;
  lei_pkg::lei_flags_t b_flags;
  logic [DW-1:0]       b_den;
  logic [TSW-1:0]      b_tx, b_ty;
  logic [UXW-1:0]      b_ux;
  logic [UYW-1:0]      b_uy;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    {b_flags, b_den, b_tx, b_ty, b_ux, b_uy} <= q_mem[q_rd_ptr];
  end

  lei_back #(.W(W), .DW(DW), .TSW(TSW), .UXW(UXW), .UYW(UYW)) u_back (
    .clk(clk), .rst(rst), .valid_in(b_valid), .flags_in(b_flags), .den(b_den),
    .tx(b_tx), .ty(b_ty), .ux(b_ux), .uy(b_uy),
    .done(done), .hit(hit), .x_first(x_first), .y_first(y_first),
    .x_second(x_second), .y_second(y_second));

  // The queue never holds more entries than it has room for.
  `LEI_ASSERT_ALWAYS(a_queue_bound, clk, rst, q_count <= (QAW+1)'(lei_pkg::QDEPTH))
  // A miss carries all-zero coordinates.
  `LEI_ASSERT_IMPLY(a_miss_zero, clk, rst, done && !hit, x_first == '0 && y_first == '0 && x_second == '0 && y_second == '0)
  // The two x coordinates come out in order.
  `LEI_ASSERT_IMPLY(a_x_order, clk, rst, done && hit, x_first <= x_second)
  // Reset leaves no result behind.
  `LEI_ASSERT_NEXT(a_reset_quiet, clk, 1'b0, rst, !done)
endmodule

>>> bench/line_ellipse_intersection_tb.sv
`timescale 1ns / 1ps
module line_ellipse_intersection_tb;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  // Exact intermediates need about 10 words plus the fraction shifts.
  localparam int WIDE = 416;
  // Leave a margin on the drain wait beyond the pipeline depth.
  localparam int DRAIN_CYCLES = 800;
  localparam int NUM_RANDOM = 1250;

  typedef logic signed [WIDE-1:0] wide_t;

  // One intersection request; hold_for_drain makes the sender wait until
  // every earlier request has produced its result before sending this one.
  typedef struct {
    logic [WORD_BITS-2:0]        major;
    logic [WORD_BITS-2:0]        minor;
    logic signed [WORD_BITS-1:0] slope;
    logic signed [WORD_BITS-1:0] icept;
    bit                          hold_for_drain;
  } query_t;

  // One intersection result as the block reports it.
  typedef struct {
    logic                        hit;
    logic signed [WORD_BITS-1:0] x1;
    logic signed [WORD_BITS-1:0] y1;
    logic signed [WORD_BITS-1:0] x2;
    logic signed [WORD_BITS-1:0] y2;
  } points_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [WORD_BITS-2:0] x_radius;
  logic [WORD_BITS-2:0] y_radius;
  logic signed [WORD_BITS-1:0] slope;
  logic signed [WORD_BITS-1:0] intercept;
  logic done;
  logic hit;
  logic signed [WORD_BITS-1:0] x_first;
  logic signed [WORD_BITS-1:0] y_first;
  logic signed [WORD_BITS-1:0] x_second;
  logic signed [WORD_BITS-1:0] y_second;

  query_t  pending_queries[$];
  points_t expected_points[$];
  int      mismatches = 0;
  bit      stimulus_done = 0;

  line_ellipse_intersection #(
    .WORD_BITS(WORD_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .x_radius(x_radius),
    .y_radius(y_radius),
    .slope(slope),
    .intercept(intercept),
    .done(done),
    .hit(hit),
    .x_first(x_first),
    .y_first(y_first),
    .x_second(x_second),
    .y_second(y_second)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Floor square root of a nonnegative wide value, one result bit per step.
  // The flag tells whether the root was exact.
  function automatic void floor_sqrt(input wide_t radicand, output wide_t root_val,
                                     output bit exact);
    logic [WIDE-1:0] rem;
    logic [WIDE-1:0] trial;
    logic [WIDE-1:0] res;
    logic [WIDE-1:0] rad;
    rad = radicand;
    rem = '0;
    res = '0;
    for (int i = WIDE / 2 - 1; i >= 0; i--) begin
      rem = (rem << 2) | rad[2*i +: 2];
      trial = (res << 2) | 1;
      res = res << 1;
      if (rem >= trial) begin
        rem = rem - trial;
        res = res | 1;
      end
    end
    root_val = res;
    exact = (rem == 0);
  endfunction

  // floor(num / den) for den > 0, then clamped to the signed word range.
  function automatic logic signed [WORD_BITS-1:0] floor_div_sat(input wide_t num,
                                                                input wide_t den);
    wide_t q;
    wide_t hi;
    wide_t lo;
    q = num / den;
    if (num < 0 && (num % den) != 0) q = q - 1;
    hi = (wide_t'(1) <<< (WORD_BITS - 1)) - 1;
    lo = -(wide_t'(1) <<< (WORD_BITS - 1));
    if (q > hi) return {1'b0, {(WORD_BITS-1){1'b1}}};
    if (q < lo) return {1'b1, {(WORD_BITS-1){1'b0}}};
    return q[WORD_BITS-1:0];
  endfunction

  // Both roots (u - sqrt(t)) / den and (u + sqrt(t)) / den, each floored.
  // The lower root rounds sqrt up when it is inexact so that the floor holds.
  function automatic void root_pair(input wide_t u, input wide_t t, input wide_t den,
                                    output logic signed [WORD_BITS-1:0] lower,
                                    output logic signed [WORD_BITS-1:0] upper);
    wide_t r;
    bit exact;
    floor_sqrt(t, r, exact);
    upper = floor_div_sat(u + r, den);
    lower = floor_div_sat(u - (exact ? r : r + 1), den);
  endfunction

  // Intersection of y = m*x + k with x^2/A^2 + y^2/B^2 = 1, in exact wide
  // integers scaled by the fraction bits.
  function automatic points_t intersect_points(input query_t q);
    points_t p;
    wide_t a, b, m, k, a2, b2, m2, a2m2, b2s, k2s, den, disc, tx, ty, ux, uy;
    logic signed [WORD_BITS-1:0] y_lo, y_hi;
    p = '{hit: 1'b0, x1: '0, y1: '0, x2: '0, y2: '0};
    a = wide_t'({1'b0, q.major});
    b = wide_t'({1'b0, q.minor});
    m = wide_t'(q.slope);
    k = wide_t'(q.icept);
    if (a == 0) return p;
    a2 = a * a;
    b2 = b * b;
    m2 = m * m;
    a2m2 = a2 * m2;
    b2s = b2 <<< (2 * FRAC_BITS);
    k2s = (k * k) <<< (2 * FRAC_BITS);
    den = b2s + a2m2;
    // Zero leading coefficient: no hit.
    if (den == 0) return p;
    disc = a2m2 + b2s - k2s;
    // A negative discriminant misses, unless the ellipse is flat (zero minor
    // radius), where the product with b^2 forces a tangent touch instead.
    if (b != 0 && disc < 0) return p;
    tx = a2 * b2 * disc;
    ty = tx * m2;
    tx = tx <<< (2 * FRAC_BITS);
    ux = -(a2 * m * k) <<< FRAC_BITS;
    uy = k * b2s;
    p.hit = 1'b1;
    root_pair(ux, tx, den, p.x1, p.x2);
    root_pair(uy, ty, den, y_lo, y_hi);
    // With a falling line the smaller x has the larger y.
    if (q.slope < 0) begin
      p.y1 = y_hi;
      p.y2 = y_lo;
    end else begin
      p.y1 = y_lo;
      p.y2 = y_hi;
    end
    return p;
  endfunction

  // Sender: bursts of random length separated by random gaps. The expected
  // result is computed when a request is taken at the edge.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    bit taken;
    bit send;
    query_t q;
    if (rst) begin
      start <= 1'b0;
      x_radius <= '0;
      y_radius <= '0;
      slope <= '0;
      intercept <= '0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        expected_points.push_back(intersect_points(pending_queries[0]));
        void'(pending_queries.pop_front());
        if (burst_left > 0) burst_left--;
      end
      send = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_queries.size() > 0) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
        end
        if (gap_left == 0) begin
          q = pending_queries[0];
          // The drain hold counts the request just taken as still in flight.
          send = !(q.hold_for_drain && (expected_points.size() > 0 || taken));
        end
      end
      if (send) begin
        start <= 1'b1;
        x_radius <= q.major;
        y_radius <= q.minor;
        slope <= q.slope;
        intercept <= q.icept;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Results cannot be held off, so every done cycle is checked against the
  // oldest expectation.
  always @(posedge clk) begin
    points_t e;
    if (!rst && done) begin
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with no request pending: hit=%0d x1=%0d",
                                       hit, x_first);
      end else begin
        e = expected_points.pop_front();
        if (hit !== e.hit || x_first !== e.x1 || y_first !== e.y1 ||
            x_second !== e.x2 || y_second !== e.y2) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp hit=%0d x1=%0d y1=%0d x2=%0d y2=%0d",
                     e.hit, e.x1, e.y1, e.x2, e.y2);
            $display("         got hit=%0d x1=%0d y1=%0d x2=%0d y2=%0d",
                     hit, x_first, y_first, x_second, y_second);
          end
        end
      end
    end
  end

  function automatic query_t make_query(input logic [WORD_BITS-2:0] maj,
                                        input logic [WORD_BITS-2:0] mnr,
                                        input logic signed [WORD_BITS-1:0] m,
                                        input logic signed [WORD_BITS-1:0] k);
    query_t q;
    q.major = maj;
    q.minor = mnr;
    q.slope = m;
    q.icept = k;
    q.hold_for_drain = 1'b0;
    return q;
  endfunction

  // Random request with a mix of scales: mostly moderate geometry where hits
  // and misses both occur, some full-range words that exercise saturation.
  function automatic query_t random_query();
    int unsigned mode;
    logic [WORD_BITS-2:0] maj, mnr;
    logic signed [WORD_BITS-1:0] m, k;
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      maj = (WORD_BITS-1)'($urandom());
      mnr = (WORD_BITS-1)'($urandom());
      m = $urandom();
      k = $urandom();
    end else begin
      maj = (WORD_BITS-1)'($urandom_range(1, 32'h0040_0000));
      mnr = (WORD_BITS-1)'($urandom_range(0, 32'h0040_0000));
      m = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      k = $signed($urandom_range(0, 2 * mnr + 2)) - $signed(mnr) - 1;
      if (mode == 9) m = '0;
      if (mode == 8) maj = '0;
    end
    return make_query(maj, mnr, m, k);
  endfunction

  initial begin
    query_t q;
    rst = 1'b1;

    // Directed part: zero major radius, zero leading coefficient, flat
    // ellipse with a slanted line, tangent, clear miss, and field extremes.
    pending_queries.push_back(make_query('0, 31'h0001_0000, 32'sh0001_0000, '0));
    pending_queries.push_back(make_query(31'h0002_0000, '0, '0, 32'sh0001_0000));
    pending_queries.push_back(make_query(31'h0002_0000, '0, 32'sh0001_0000, 32'sh0003_0000));
    pending_queries.push_back(make_query(31'h0002_0000, '0, -32'sh0002_0000,
                                         -32'sh0001_8000));
    pending_queries.push_back(make_query(31'h0002_0000, 31'h0001_0000, '0, 32'sh0001_0000));
    pending_queries.push_back(make_query(31'h0002_0000, 31'h0001_0000, '0, 32'sh0002_0000));
    pending_queries.push_back(make_query(31'h0002_0000, 31'h0001_0000, 32'sh0000_8000,
                                         -32'sh0000_4000));
    pending_queries.push_back(make_query(31'h0003_0000, 31'h0002_0000, -32'sh0001_0000,
                                         32'sh0000_1000));
    pending_queries.push_back(make_query('1, '1, 32'sh7fff_ffff, 32'sh7fff_ffff));
    pending_queries.push_back(make_query('1, '1, 32'sh8000_0000, 32'sh8000_0000));
    pending_queries.push_back(make_query('1, '1, '0, '0));
    pending_queries.push_back(make_query(31'd1, 31'd1, 32'sh7fff_ffff, '0));
    pending_queries.push_back(make_query(31'd1, '1, 32'sh8000_0000, 32'sh0000_0001));
    pending_queries.push_back(make_query('1, 31'd1, 32'sh0000_0001, -32'sd1));
    pending_queries.push_back(make_query(31'h5555_5555, 31'h2aaa_aaaa, 32'sh5555_5555,
                                         32'shaaaa_aaaa));
    pending_queries.push_back(make_query(31'h2aaa_aaaa, 31'h5555_5555, 32'shaaaa_aaaa,
                                         32'sh5555_5555));

    for (int i = 0; i < NUM_RANDOM; i++) begin
      q = random_query();
      // A few times the sender waits for the pipeline to empty completely.
      if (i % 400 == 200) q.hold_for_drain = 1'b1;
      pending_queries.push_back(q);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_queries.size() != 0 || expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("line_ellipse_intersection_tb OK");
    end else begin
      $display("line_ellipse_intersection_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("line_ellipse_intersection_tb NOT OK");
    $finish;
  end

endmodule
